>>> hw/rtl/blad_pkg.sv
// shared types and constants of the bit angle led driver
`timescale 1ns / 1ps

package blad_pkg;

	localparam int LEVEL_W = 16;

	// operation codes carried in s_tuser
	localparam logic [1:0] OP_BYTE    = 2'd0;
	localparam logic [1:0] OP_TIMEOUT = 2'd1;
	localparam logic [1:0] OP_TICK    = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_PERIOD_BASE  = 2'd0;
	localparam logic [1:0] CFG_DEAD_TIME    = 2'd1;
	localparam logic [1:0] CFG_SHIFT_CYCLES = 2'd2;
	localparam logic [1:0] CFG_STEP_OFFSET  = 2'd3;

	// packet framing
	localparam logic [7:0] CMD_SET_STEP = 8'h23;
	localparam logic [3:0] PACKET_LAST  = 4'd9;

	// level write from a completed packet; level[0..3] go to channels 4*step+0..3 (w, r, g, b)
	typedef struct packed {
		logic                          en;
		logic [7:0]                    step;
		logic [3:0][LEVEL_W-1:0]       level;
	} level_wr_t;

endpackage

>>> hw/rtl/bit_angle_led_driver.sv
// top level of the bit angle led driver
`timescale 1ns / 1ps

// Binary code modulation LED driver. Each input transaction carries an op in s_tuser
// (received byte, byte-gap timeout, period end tick) and a byte in s_tdata. Ten-byte
// set-step packets (0x23, step, then r, g, b, w as little-endian 16-bit values) load four
// channel levels; a tick returns the current bit plane and the timer reload for the next
// period. One transaction is accepted per clock cycle unless the input stalls; a tick result
// appears on m_tdata once the input register holds the tick and the output register takes
// the result. The input stalls only while a held result is not taken.
// Levels reset to zero with no clearing pass.
module bit_angle_led_driver #(
	parameter int CHANNELS = 32,
	parameter int PLANES   = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic [1:0]  s_tuser,   // [1:0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [31:0] plane_word, [46:32] reload_cycles, [47] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import blad_pkg::*;

	localparam logic [3:0] PLANE_LSB = 4'(16 - PLANES);

	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [7:0]  byte_s1;
	logic        advance;
	logic        tick;
	logic [3:0]  plane_idx_q;
	logic [3:0]  plane_cur;
	logic [3:0]  plane_next;
	logic [3:0]  period_base_q;
	logic [3:0]  dead_time_q;
	logic [7:0]  shift_cycles_q;
	logic [7:0]  step_offset_q;
	logic [19:0] reload_full;
	logic [31:0] plane_word;
	logic        out_valid_q;
	logic [47:0] out_data_q;
	level_wr_t   wr;

	// the input stage moves on when the output register can take a result
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign tick     = valid_s1 && advance && (op_s1 == OP_TICK);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1   <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_base_q  <= 4'd4;
			dead_time_q    <= 4'd4;
			shift_cycles_q <= 8'd128;
			step_offset_q  <= 8'd8;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_PERIOD_BASE:  period_base_q  <= cfg_data[3:0];
				CFG_DEAD_TIME:    dead_time_q    <= cfg_data[3:0];
				CFG_SHIFT_CYCLES: shift_cycles_q <= cfg_data;
				CFG_STEP_OFFSET:  step_offset_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// packet assembly
	blad_packet #(
		.STEPS (CHANNELS / 4)
	) u_packet (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_en     (valid_s1 && advance && (op_s1 == OP_BYTE)),
		.restart     (valid_s1 && advance && (op_s1 == OP_TIMEOUT)),
		.rx_byte     (byte_s1),
		.step_offset (step_offset_q),
		.wr          (wr)
	);

	// plane sequencing
	always_comb begin
		plane_cur = plane_idx_q;
		if ({1'b0, plane_idx_q} >= 5'(PLANES)) begin
			plane_cur = '0;
		end
		plane_next = plane_cur + 4'd1;
		if (({1'b0, plane_cur} + 5'd1) >= 5'(PLANES)) begin
			plane_next = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_idx_q <= '0;
		end else if (tick) begin
			plane_idx_q <= plane_next;
		end
	end

	// brightness store
	blad_store #(
		.CHANNELS (CHANNELS)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (wr),
		.plane_bit  (plane_cur + PLANE_LSB),
		.plane_word (plane_word)
	);

	// timer reload for the next period
	assign reload_full = (20'(period_base_q) << plane_next) + 20'(dead_time_q)
		+ 20'(shift_cycles_q);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= tick;
		end
	end

	always_ff @(posedge clk) begin
		if (tick) begin
			out_data_q <= {1'b0, reload_full[14:0], plane_word};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

`ifndef SYNTH
	// plane index stays inside the plane count
	a_plane_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, plane_idx_q} < 5'(PLANES))
		else $error("plane index out of range");

	// plane index moves only on a tick
	a_plane_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!tick |=> $stable(plane_idx_q))
		else $error("plane index changed without a tick");

	// a tick always leaves a result behind
	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		tick |=> m_tvalid)
		else $error("tick produced no result");

	// an empty input stage never stalls the input
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input stalled while empty");
`endif

endmodule

>>> hw/rtl/blad_packet.sv
// packet assembler: collects serial bytes and decodes set-step packets
`timescale 1ns / 1ps

module blad_packet #(
	parameter int STEPS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_en,
	input  logic                restart,
	input  logic [7:0]          rx_byte,
	input  logic [7:0]          step_offset,
	output blad_pkg::level_wr_t wr
);
	import blad_pkg::*;

	logic [3:0]       pos_q;
	logic [7:0]       bytes_q [9];
	logic             last_byte;
	logic [7:0]       step_rel;
	logic             step_ok;

	assign last_byte = (pos_q >= PACKET_LAST);
	assign step_rel  = bytes_q[1] - step_offset;
	assign step_ok   = (bytes_q[1] >= step_offset) && (step_rel < 8'(STEPS));

	// byte position within the packet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (restart) begin
			pos_q <= '0;
		end else if (byte_en) begin
			if (last_byte) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + 4'd1;
			end
		end
	end

	// held packet bytes, no reset needed
	always_ff @(posedge clk) begin
		if (byte_en && !last_byte) begin
			bytes_q[pos_q] <= rx_byte;
		end
	end

	// decode on the final byte
	always_comb begin
		wr.en       = byte_en && last_byte && (bytes_q[0] == CMD_SET_STEP) && step_ok;
		wr.step     = step_rel;
		wr.level[0] = {rx_byte, bytes_q[8]};
		wr.level[1] = {bytes_q[3], bytes_q[2]};
		wr.level[2] = {bytes_q[5], bytes_q[4]};
		wr.level[3] = {bytes_q[7], bytes_q[6]};
	end

endmodule

>>> hw/rtl/blad_store.sv
// brightness store and bit plane extraction
`timescale 1ns / 1ps

module blad_store #(
	parameter int CHANNELS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  blad_pkg::level_wr_t wr,
	input  logic [3:0]          plane_bit,
	output logic [31:0]         plane_word
);
	import blad_pkg::*;

	logic [LEVEL_W-1:0] level_q [CHANNELS];

	// per-channel brightness, each written when its step is addressed
	for (genvar j = 0; j < CHANNELS; j++) begin : g_chan
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				level_q[j] <= '0;
			end else if (wr.en && (wr.step == 8'(j / 4))) begin
				level_q[j] <= wr.level[j % 4];
			end
		end
	end

	// pick one bit of every channel; unused lanes read zero
	for (genvar j = 0; j < 32; j++) begin : g_bit
		if (j < CHANNELS) begin : g_used
			assign plane_word[j] = level_q[j][plane_bit];
		end else begin : g_unused
			assign plane_word[j] = 1'b0;
		end
	end

endmodule
